// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

   // Operand width used unless the top level is told otherwise
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed widths of the channel words
   localparam int FIELD_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 8;

   // Register indexes on the configuration channel
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 8'd1;

   // Register values after reset
   localparam logic [FIELD_WIDTH-1:0] EXPONENT_RESET = 32'd1;
   localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET  = 32'hFFFF_FFFF;

endpackage

// ===== rtl/mexp_if.sv =====
// Input channel: one message word per handshake
interface mexp_msg_if;
   logic                           valid;
   logic                           ready;
   logic [mexp_pkg::FIELD_WIDTH-1:0] message;

   modport source (output valid, output message, input ready);
   modport sink   (input valid, input message, output ready);
endinterface

// Result channel: one result word per handshake
interface mexp_res_if;
   logic                           valid;
   logic                           ready;
   logic [mexp_pkg::FIELD_WIDTH-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

// Configuration write channel
interface mexp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [mexp_pkg::FIELD_WIDTH-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: product = op_a * op_b mod modulus.
// op_a is scanned MSB first, one bit per cycle; op_b and modulus must be
// below 2^W, op_b below modulus, and modulus held stable while busy.
module mexp_mulmod #(
   parameter int W = mexp_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] op_a,
   input  logic [W-1:0] op_b,
   input  logic [W-1:0] modulus,
   output logic         busy,
   output logic         done,
   output logic [W-1:0] product
);
   import mexp_pkg::*;

   localparam int CntW = $clog2(W + 1);

   logic [W-1:0]    a_sh_ff, a_sh_in;
   logic [W-1:0]    b_ff, b_in;
   logic [W-1:0]    r_ff, r_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   logic [W+1:0] sum;
   logic [W+2:0] diff1;
   logic [W+2:0] diff2;

   // One step: r = 2r + a_bit*b, then pull back below modulus (value < 3n)
   always_comb begin
      sum   = {1'b0, r_ff, 1'b0} + (a_sh_ff[W-1] ? {2'b00, b_ff} : {(W+2){1'b0}});
      diff1 = {1'b0, sum} - {3'b000, modulus};
      diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
   end

   // Control and datapath next state
   always_comb begin
      a_sh_in = a_sh_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_sh_in = op_a;
         b_in    = op_b;
         r_in    = '0;
         cnt_in  = CntW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_sh_in = {a_sh_ff[W-2:0], 1'b0};
         priority if (!diff2[W+2]) begin
            r_in = diff2[W-1:0];
         end else if (!diff1[W+2]) begin
            r_in = diff1[W-1:0];
         end else begin
            r_in = sum[W-1:0];
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sh_ff <= a_sh_in;
      b_ff    <= b_in;
      r_ff    <= r_in;
      cnt_ff  <= cnt_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = r_ff;

   // Partial remainder stays reduced throughout an operation
   a_r_reduced: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (r_ff < modulus))
      else $error("mulmod: partial remainder not below modulus");

   // Done is a single pulse after the last step
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("mulmod: done while still busy");

   // A start always launches an operation
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("mulmod: start did not set busy");

endmodule

// ===== rtl/modular_exponentiation_top.sv =====
// Modular exponentiation (textbook RSA): each message word returns one result
// word, message^exponent mod modulus, using the low DATA_WIDTH bits of message,
// exponent and modulus. A modulus below two gives 0; an exponent of zero gives
// 1. Write the exponent (index 0) and modulus (index 1) while the block is idle.
// One word is processed at a time, right-to-left square-and-multiply over a
// bit-serial modular multiplier that retires one multiplier bit per cycle.
// The message is first reduced by one modular product. Then each exponent bit
// up to the highest set bit takes a decision step, a multiply if it is set and
// a square if it lies below the highest set bit; a final decision and the
// hand-off follow. A finished result is held in an output register until
// taken; while it waits the next word may be worked on, but that word's
// hand-off stalls until the register is free.
module modular_exponentiation_top #(
   parameter int DATA_WIDTH = mexp_pkg::DATA_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   mexp_msg_if.sink   req_ch,
   mexp_res_if.source rsp_ch,
   mexp_csr_if.sink   csr_ch
);
   import mexp_pkg::*;

   localparam int W = DATA_WIDTH;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REDUCE = 3'd1;
   localparam logic [2:0] S_LOOP   = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_SQR    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [FIELD_WIDTH-1:0] csr_exponent_ff, csr_exponent_in;
   logic [FIELD_WIDTH-1:0] csr_modulus_ff, csr_modulus_in;
   logic [2:0]             state_ff, state_in;
   logic [W-1:0]           exp_ff, exp_in;
   logic [W-1:0]           n_ff, n_in;
   logic [W-1:0]           base_ff, base_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_result_ff, rsp_result_in;

   logic         req_accept;
   logic         csr_accept;
   logic [W-1:0] cfg_n;
   logic         cfg_n_ok;
   logic         mm_start;
   logic [W-1:0] mm_a;
   logic [W-1:0] mm_b;
   logic         mm_busy;
   logic         mm_done;
   logic [W-1:0] mm_product;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign csr_accept = csr_ch.valid && csr_ch.ready;
   assign cfg_n      = csr_modulus_ff[W-1:0];
   assign cfg_n_ok   = |cfg_n[W-1:1];

   // Configuration registers
   always_comb begin
      csr_exponent_in = csr_exponent_ff;
      csr_modulus_in  = csr_modulus_ff;
      if (csr_accept) begin
         if (csr_ch.index == CSR_EXPONENT) begin
            csr_exponent_in = csr_ch.data;
         end else if (csr_ch.index == CSR_MODULUS) begin
            csr_modulus_in = csr_ch.data;
         end
      end
   end

   // Square-and-multiply sequencer
   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      n_in          = n_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      mm_start      = 1'b0;
      mm_a          = base_ff;
      mm_b          = base_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               n_in = cfg_n;
               if (cfg_n_ok) begin
                  // reduce the message first: message * 1 mod n
                  exp_in   = csr_exponent_ff[W-1:0];
                  acc_in   = W'(1);
                  mm_start = 1'b1;
                  mm_a     = req_ch.message[W-1:0];
                  mm_b     = W'(1);
                  state_in = S_REDUCE;
               end else begin
                  exp_in   = '0;
                  acc_in   = '0;
                  state_in = S_LOOP;
               end
            end
         end
         S_REDUCE: begin
            if (mm_done) begin
               base_in  = mm_product;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (exp_ff == '0) begin
               state_in = S_FINISH;
            end else if (exp_ff[0]) begin
               mm_start = 1'b1;
               mm_a     = acc_ff;
               state_in = S_MUL;
            end else begin
               mm_start = 1'b1;
               state_in = S_SQR;
            end
         end
         S_MUL: begin
            if (mm_done) begin
               acc_in = mm_product;
               // skip the square after the top exponent bit
               if (exp_ff[W-1:1] == '0) begin
                  exp_in   = exp_ff >> 1;
                  state_in = S_LOOP;
               end else begin
                  mm_start = 1'b1;
                  state_in = S_SQR;
               end
            end
         end
         S_SQR: begin
            if (mm_done) begin
               base_in  = mm_product;
               exp_in   = exp_ff >> 1;
               state_in = S_LOOP;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = FIELD_WIDTH'(acc_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_exponent_ff <= EXPONENT_RESET;
         csr_modulus_ff  <= MODULUS_RESET;
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         csr_exponent_ff <= csr_exponent_in;
         csr_modulus_ff  <= csr_modulus_in;
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff        <= exp_in;
      n_ff          <= n_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      rsp_result_ff <= rsp_result_in;
   end

   mexp_mulmod #(
      .W(W)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (n_ff),
      .busy    (mm_busy),
      .done    (mm_done),
      .product (mm_product)
   );

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.result = rsp_result_ff;

   // An accepted word always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("top: accepted word did not start work");

   // The accumulator is reduced when the result is handed off
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && (|n_ff[W-1:1])) |-> (acc_ff < n_ff))
      else $error("top: result not below modulus");

   // Multiplier completions only arrive while the sequencer waits for one
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mm_done |-> ((state_ff == S_REDUCE) || (state_ff == S_MUL) || (state_ff == S_SQR)))
      else $error("top: unexpected multiplier completion");

   // The multiplier is never restarted while an operation is running
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      mm_busy |-> !mm_start)
      else $error("top: multiplier started while busy");

endmodule
